[design/repeater_control_fsm_core_assert.svh]
`ifndef REPEATER_CONTROL_FSM_CORE_ASSERT_SVH
`define REPEATER_CONTROL_FSM_CORE_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define RCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define RCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/rcf_pkg.sv]
package rcf_pkg;

  // width of the millisecond time base; differences wrap at this width
  localparam int TIME_BITS = 48;

  // millisecond thresholds derived from second-valued registers
  localparam int MS_PER_S = 1000;
  localparam int THR_BITS = 26;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BEACON_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_DELAY      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAIT_TIMEOUT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TALK_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_TIME      = 3'd4;

  // register reset values
  localparam logic [15:0] BEACON_INTERVAL_RST = 16'd1200;
  localparam logic [15:0] OPEN_DELAY_RST      = 16'd200;
  localparam logic [15:0] WAIT_TIMEOUT_RST    = 16'd15;
  localparam logic [15:0] TALK_LIMIT_RST      = 16'd300;
  localparam logic [15:0] BLOCK_TIME_RST      = 16'd10;

  // fixed listen-state time limits, in ms
  localparam logic [TIME_BITS-1:0] LISTEN_WAIT_MS    = TIME_BITS'(7 * MS_PER_S - 1);
  localparam logic [TIME_BITS-1:0] LISTEN_CLOSE_MS   = TIME_BITS'(6 * MS_PER_S - 1);
  localparam logic [TIME_BITS-1:0] SHORT_QSO_MS      = TIME_BITS'(5 * MS_PER_S);
  localparam logic [TIME_BITS-1:0] QSO_5MIN_MS       = TIME_BITS'(5 * 60 * MS_PER_S);
  localparam logic [TIME_BITS-1:0] QSO_10MIN_MS      = TIME_BITS'(10 * 60 * MS_PER_S);
  localparam logic [TIME_BITS-1:0] QSO_15MIN_MS      = TIME_BITS'(15 * 60 * MS_PER_S);

  // message codes
  localparam logic [4:0] MSG_NONE         = 5'd0;
  localparam logic [4:0] MSG_OK           = 5'd1;
  localparam logic [4:0] MSG_SSTV         = 5'd2;
  localparam logic [4:0] MSG_LOW_POWER    = 5'd3;
  localparam logic [4:0] MSG_FREQ_HIGH    = 5'd4;
  localparam logic [4:0] MSG_FREQ_LOW     = 5'd5;
  localparam logic [4:0] MSG_SWR          = 5'd6;
  localparam logic [4:0] MSG_ANTI_CHATTER = 5'd7;
  localparam logic [4:0] MSG_73           = 5'd8;
  localparam logic [4:0] MSG_CALL         = 5'd9;
  localparam logic [4:0] MSG_CALL_ALT     = 5'd10;
  localparam logic [4:0] MSG_CALL_LOC     = 5'd11;
  localparam logic [4:0] MSG_CALL_LOC_ALT = 5'd12;
  localparam logic [4:0] MSG_BCN_LONG_73  = 5'd13;
  localparam logic [4:0] MSG_BCN_LONG_SK  = 5'd14;
  localparam logic [4:0] MSG_BCN_SPEC_73  = 5'd15;
  localparam logic [4:0] MSG_BCN_SPEC_SK  = 5'd16;

  // one update tick
  typedef struct packed {
    logic                 tone_call;
    logic                 squelch_open;
    logic                 start_beacon;
    logic                 low_power;
    logic                 swr_alarm;
    logic                 freq_low;
    logic                 freq_high;
    logic                 sstv_on;
    logic                 cw_done;
    logic                 wind_ok;
    logic [1:0]           random_bits;
    logic [TIME_BITS-1:0] now_ms;
  } item_t;

  // outputs of one update
  typedef struct packed {
    logic [3:0] state_code;
    logic       tx_on;
    logic       modulation;
    logic       cw_key;
    logic [4:0] message_code;
  } result_t;

  // timer limits as held by the register block, elapsed ms must exceed them
  typedef struct packed {
    logic [THR_BITS-1:0] beacon_thr;
    logic [15:0]         open_delay;
    logic [THR_BITS-1:0] wait_thr;
    logic [THR_BITS-1:0] talk_thr;
    logic [THR_BITS-1:0] block_thr;
  } thr_t;

  // seconds limit to ms limit: el_s > s  <=>  el_ms > s*1000 + 999
  function automatic logic [THR_BITS-1:0] sec_to_thr(input logic [15:0] s);
    sec_to_thr = THR_BITS'(s) * THR_BITS'(MS_PER_S) + THR_BITS'(MS_PER_S - 1);
  endfunction

endpackage

[design/repeater_control_fsm_core.sv]
// Repeater controller: one update tick per beat on the item channel, one result beat per
// tick. A tick is captured in an input register and decided, once the result register is
// free, against the mode, entry timestamps and held message, which are written together
// with the result register; one tick is taken every cycle while the result side keeps up.
// The mode/timestamp feedback closes through the decision logic alone, which sets the
// one-per-cycle rate. Second-valued timer registers are kept as millisecond limits,
// converted when written, so each timer check is one 48-bit subtract and compare.
// Configuration writes are always ready.
module repeater_control_fsm_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  rcf_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output rcf_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]                      cfg_data
);
  import rcf_pkg::*;

  typedef enum logic [3:0] {
    IDLE, OPEN_TONE, OPEN_DROP, LETTER, LISTEN, WAIT, TALK, ANTI_CHATTER, BLOCKED,
    TXT_73, TXT_CALL, TXT_LONG, BCN_LONG, BCN_SPEC, BCN_SHORT
  } mode_t;

  thr_t                 thr;
  logic                 in_valid;
  item_t                in_item;
  logic                 advance;
  mode_t                mode;
  mode_t                mode_next;
  logic [TIME_BITS-1:0] entry_time;
  logic [TIME_BITS-1:0] open_entry_time;
  logic [4:0]           held_message;
  logic [4:0]           held_message_next;
  logic [TIME_BITS-1:0] el_ms;
  logic [TIME_BITS-1:0] listen_dur;
  logic                 tx;
  logic                 mod;
  logic                 trig;
  logic [4:0]           letter;

  rcf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  // decide when the result register is free to take the next update
  assign advance    = in_valid && (!result_valid || result_ready);
  assign item_ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      in_item <= item;
    end
  end

  // elapsed times, wrapping
  assign el_ms      = in_item.now_ms - entry_time;
  assign listen_dur = entry_time - open_entry_time;

  // letter priority: swr, low, high, low power, sstv, ok
  always_comb begin
    if (in_item.swr_alarm)      letter = MSG_SWR;
    else if (in_item.freq_low)  letter = MSG_FREQ_LOW;
    else if (in_item.freq_high) letter = MSG_FREQ_HIGH;
    else if (in_item.low_power) letter = MSG_LOW_POWER;
    else if (in_item.sstv_on)   letter = MSG_SSTV;
    else                        letter = MSG_OK;
  end

  // transition and output decode for the current mode
  always_comb begin
    mode_next         = mode;
    held_message_next = held_message;
    tx                = 1'b0;
    mod               = 1'b0;
    trig              = 1'b0;
    case (mode)
      IDLE: begin
        if (in_item.tone_call && in_item.squelch_open) begin
          mode_next = OPEN_TONE;
        end else if (in_item.start_beacon) begin
          mode_next = (in_item.low_power || in_item.swr_alarm) ? BCN_SPEC : BCN_LONG;
        end else if (!in_item.low_power && el_ms > TIME_BITS'(thr.beacon_thr)) begin
          mode_next = BCN_SHORT;
        end
      end
      OPEN_TONE: begin
        tx = 1'b1;
        if (!in_item.squelch_open) mode_next = OPEN_DROP;
      end
      OPEN_DROP: begin
        tx  = 1'b1;
        mod = 1'b1;
        if (el_ms > TIME_BITS'(thr.open_delay)) mode_next = LETTER;
      end
      LETTER: begin
        tx                = 1'b1;
        mod               = 1'b1;
        trig              = 1'b1;
        held_message_next = letter;
        if (in_item.cw_done) mode_next = LISTEN;
      end
      LISTEN: begin
        tx  = 1'b1;
        mod = 1'b1;
        if (in_item.squelch_open) begin
          mode_next = TALK;
        end else if (el_ms > LISTEN_WAIT_MS && listen_dur < SHORT_QSO_MS) begin
          mode_next = WAIT;
        end else if (el_ms > LISTEN_CLOSE_MS) begin
          if (listen_dur < QSO_5MIN_MS)       mode_next = IDLE;
          else if (listen_dur < QSO_10MIN_MS) mode_next = TXT_73;
          else if (listen_dur < QSO_15MIN_MS) mode_next = TXT_CALL;
          else                                mode_next = TXT_LONG;
        end
      end
      WAIT: begin
        if (in_item.squelch_open)                    mode_next = LISTEN;
        else if (el_ms > TIME_BITS'(thr.wait_thr))   mode_next = IDLE;
      end
      TALK: begin
        tx  = 1'b1;
        mod = 1'b1;
        if (!in_item.squelch_open)                   mode_next = LETTER;
        else if (el_ms > TIME_BITS'(thr.talk_thr))   mode_next = ANTI_CHATTER;
      end
      ANTI_CHATTER: begin
        tx                = 1'b1;
        trig              = 1'b1;
        held_message_next = MSG_ANTI_CHATTER;
        if (in_item.cw_done) mode_next = BLOCKED;
      end
      BLOCKED: begin
        if (el_ms > TIME_BITS'(thr.block_thr)) mode_next = IDLE;
      end
      TXT_73, TXT_CALL, TXT_LONG: begin
        tx   = 1'b1;
        mod  = 1'b1;
        trig = 1'b1;
        if (mode == TXT_73)        held_message_next = MSG_73;
        else if (mode == TXT_CALL) held_message_next = MSG_CALL;
        else held_message_next = in_item.random_bits[1] ? MSG_CALL_ALT : MSG_CALL_LOC;
        if (in_item.squelch_open) mode_next = TALK;
        else if (in_item.cw_done) mode_next = IDLE;
      end
      BCN_LONG, BCN_SPEC, BCN_SHORT: begin
        tx   = 1'b1;
        trig = 1'b1;
        if (mode == BCN_LONG) begin
          held_message_next = in_item.wind_ok ? MSG_BCN_LONG_73 : MSG_BCN_LONG_SK;
        end else if (mode == BCN_SPEC) begin
          held_message_next = in_item.wind_ok ? MSG_BCN_SPEC_73 : MSG_BCN_SPEC_SK;
        end else begin
          case (in_item.random_bits)
            2'd0:    held_message_next = MSG_CALL;
            2'd1:    held_message_next = MSG_CALL_LOC;
            2'd2:    held_message_next = MSG_CALL_ALT;
            default: held_message_next = MSG_CALL_LOC_ALT;
          endcase
        end
        if (in_item.squelch_open) mode_next = OPEN_DROP;
        else if (in_item.cw_done) mode_next = IDLE;
      end
      default: begin
        mode_next = IDLE;
      end
    endcase
  end

  // state, entry stamps and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= IDLE;
      entry_time      <= '0;
      open_entry_time <= '0;
      held_message    <= MSG_NONE;
      result_valid    <= 1'b0;
    end else begin
      if (advance) begin
        mode         <= mode_next;
        held_message <= held_message_next;
        if (mode_next != mode) begin
          entry_time <= in_item.now_ms;
          if (mode_next == OPEN_DROP) open_entry_time <= in_item.now_ms;
        end
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (advance) begin
      result.state_code   <= 4'(mode_next);
      result.tx_on        <= tx;
      result.modulation   <= mod;
      result.cw_key       <= trig;
      result.message_code <= held_message_next;
    end
  end

endmodule

[design/rcf_cfg_regs.sv]
module rcf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]                      cfg_data,
  output rcf_pkg::thr_t                    thr
);
  import rcf_pkg::*;

  logic [THR_BITS-1:0] data_thr;

  // writes always taken
  assign cfg_ready = 1'b1;

  // seconds converted to ms limits once, at write time
  assign data_thr = sec_to_thr(cfg_data);

  // register file, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.beacon_thr <= sec_to_thr(BEACON_INTERVAL_RST);
      thr.open_delay <= OPEN_DELAY_RST;
      thr.wait_thr   <= sec_to_thr(WAIT_TIMEOUT_RST);
      thr.talk_thr   <= sec_to_thr(TALK_LIMIT_RST);
      thr.block_thr  <= sec_to_thr(BLOCK_TIME_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BEACON_INTERVAL: thr.beacon_thr <= data_thr;
        CFG_OPEN_DELAY:      thr.open_delay <= cfg_data;
        CFG_WAIT_TIMEOUT:    thr.wait_thr   <= data_thr;
        CFG_TALK_LIMIT:      thr.talk_thr   <= data_thr;
        CFG_BLOCK_TIME:      thr.block_thr  <= data_thr;
        default: ;
      endcase
    end
  end

endmodule

[design/rcf_checker.sv]
`include "repeater_control_fsm_core_assert.svh"

module rcf_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input rcf_pkg::result_t result
);
  import rcf_pkg::*;

  logic stalled;
  logic mod_on;
  logic cw_on;
  logic cw_ok;

  // terms used by the checks below
  assign stalled = result_valid && !result_ready;
  assign mod_on  = result_valid && result.modulation;
  assign cw_on   = result_valid && result.cw_key;
  assign cw_ok   = result.tx_on && (result.message_code != MSG_NONE);

  // a stalled result beat holds
  `RCF_ASSERT_NEXT(a_result_hold, stalled, result_valid && $stable(result), "stalled beat changed")

  // audio is only relayed on a keyed transmitter
  `RCF_ASSERT_NOW(a_mod_keyed, mod_on, result.tx_on, "modulation without tx")

  // morse is only sent on a keyed transmitter and always has a message
  `RCF_ASSERT_NOW(a_cw_keyed, cw_on, cw_ok, "cw key without tx or message")

  // the spare mode code is never reported
  `RCF_ASSERT_NOW(a_state_range, result_valid, result.state_code != 4'd15, "unused state code")

endmodule

bind repeater_control_fsm_core rcf_checker u_rcf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

[tb/repeater_control_fsm_core_tb.sv]
module repeater_control_fsm_core_tb;
  import rcf_pkg::*;

  // controller modes, numbered as the block reports them in state_code
  typedef enum logic [3:0] {
    ST_IDLE, ST_OPEN_TONE, ST_OPEN_GONE, ST_LETTER, ST_LISTEN, ST_WAIT, ST_TALK,
    ST_ANTI_CHATTER, ST_BLOCKED, ST_TEXT_73, ST_TEXT_CALL, ST_TEXT_LONG,
    ST_BEACON_LONG, ST_BEACON_SPECIAL, ST_BEACON_SHORT
  } mode_t;

  // register settings visited by the run, one per phase
  typedef enum {
    SET_POWER_ON, SET_ALL_ZERO, SET_ALL_MAX, SET_SHORT, SET_RANDOM, SET_DEFAULTS
  } setting_t;

  // listen-state limits
  localparam int unsigned MS_IN_S          = 1000;
  localparam int unsigned QUIET_TO_WAIT_S  = 6;
  localparam int unsigned QUIET_TO_CLOSE_S = 5;
  localparam int unsigned SHORT_CALL_MS    = 5000;
  localparam int unsigned QUICK_CLOSE_MS   = 300000;
  localparam int unsigned TEXT_73_MS       = 600000;
  localparam int unsigned TEXT_CALL_MS     = 900000;

  // flag bits of a tick, in item_t order from tone_call down to wind_ok
  localparam logic [9:0] F_NONE      = 10'b00_0000_0000;
  localparam logic [9:0] F_TONE      = 10'b10_0000_0000;
  localparam logic [9:0] F_SQUELCH   = 10'b01_0000_0000;
  localparam logic [9:0] F_START     = 10'b00_1000_0000;
  localparam logic [9:0] F_LOW_POWER = 10'b00_0100_0000;
  localparam logic [9:0] F_SWR       = 10'b00_0010_0000;
  localparam logic [9:0] F_FREQ_LOW  = 10'b00_0001_0000;
  localparam logic [9:0] F_FREQ_HIGH = 10'b00_0000_1000;
  localparam logic [9:0] F_SSTV      = 10'b00_0000_0100;
  localparam logic [9:0] F_DONE      = 10'b00_0000_0010;
  localparam logic [9:0] F_WIND      = 10'b00_0000_0001;
  localparam logic [9:0] F_LETTERS   = F_SWR | F_FREQ_LOW | F_FREQ_HIGH | F_LOW_POWER | F_SSTV;
  localparam logic [9:0] F_ALL       = F_TONE | F_SQUELCH | F_START | F_LETTERS | F_DONE | F_WIND;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_FIRST = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_LAST  = 3'd7;

  localparam int ITEMS_PER_PHASE = 265;
  localparam int MAX_REPORTS     = 100;

  // repeater controller prediction and result check
  class update_scoreboard;
    logic [15:0]          beacon_s, open_delay_ms, wait_s, talk_s, block_s;
    mode_t                mode;
    logic [TIME_BITS-1:0] entry_ms, open_entry_ms;
    logic [4:0]           held_msg;
    result_t              expected_updates[$];
    int unsigned          mismatches, updates_checked, ticks_noted;
    bit [15:0]            modes_seen;
    bit [16:0]            msgs_seen;

    function new();
      beacon_s      = BEACON_INTERVAL_RST;
      open_delay_ms = OPEN_DELAY_RST;
      wait_s        = WAIT_TIMEOUT_RST;
      talk_s        = TALK_LIMIT_RST;
      block_s       = BLOCK_TIME_RST;
      mode          = ST_IDLE;
      entry_ms      = '0;
      open_entry_ms = '0;
      held_msg      = MSG_NONE;
    endfunction

    function int pending();
      return expected_updates.size();
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_BEACON_INTERVAL: beacon_s = data;
        CFG_OPEN_DELAY:      open_delay_ms = data;
        CFG_WAIT_TIMEOUT:    wait_s = data;
        CFG_TALK_LIMIT:      talk_s = data;
        CFG_BLOCK_TIME:      block_s = data;
        default: ;
      endcase
    endfunction

    // one accepted tick: outputs follow the current mode, then the mode moves on
    function void note_tick(item_t t);
      logic [TIME_BITS-1:0] el_ms, el_s, listen_ms;
      mode_t                nxt;
      result_t              r;
      el_ms     = t.now_ms - entry_ms;
      el_s      = el_ms / MS_IN_S;
      listen_ms = entry_ms - open_entry_ms;
      nxt       = mode;
      r         = '0;
      case (mode)
        ST_IDLE: begin
          if (t.tone_call && t.squelch_open) nxt = ST_OPEN_TONE;
          else if (t.start_beacon)
            nxt = (t.low_power || t.swr_alarm) ? ST_BEACON_SPECIAL : ST_BEACON_LONG;
          else if (!t.low_power && el_s > beacon_s) nxt = ST_BEACON_SHORT;
        end
        ST_OPEN_TONE: begin
          r.tx_on = 1'b1;
          if (!t.squelch_open) nxt = ST_OPEN_GONE;
        end
        ST_OPEN_GONE: begin
          r.tx_on = 1'b1;
          r.modulation = 1'b1;
          if (el_ms > open_delay_ms) nxt = ST_LETTER;
        end
        ST_LETTER: begin
          r.tx_on = 1'b1;
          r.modulation = 1'b1;
          r.cw_key = 1'b1;
          // letter priority: swr, low, high, low power, sstv, ok
          if (t.swr_alarm) held_msg = MSG_SWR;
          else if (t.freq_low) held_msg = MSG_FREQ_LOW;
          else if (t.freq_high) held_msg = MSG_FREQ_HIGH;
          else if (t.low_power) held_msg = MSG_LOW_POWER;
          else if (t.sstv_on) held_msg = MSG_SSTV;
          else held_msg = MSG_OK;
          if (t.cw_done) nxt = ST_LISTEN;
        end
        ST_LISTEN: begin
          r.tx_on = 1'b1;
          r.modulation = 1'b1;
          if (t.squelch_open) nxt = ST_TALK;
          else if (el_s > QUIET_TO_WAIT_S && listen_ms < SHORT_CALL_MS) nxt = ST_WAIT;
          else if (el_s > QUIET_TO_CLOSE_S) begin
            // closing text chosen by how long the whole exchange ran
            if (listen_ms < QUICK_CLOSE_MS) nxt = ST_IDLE;
            else if (listen_ms < TEXT_73_MS) nxt = ST_TEXT_73;
            else if (listen_ms < TEXT_CALL_MS) nxt = ST_TEXT_CALL;
            else nxt = ST_TEXT_LONG;
          end
        end
        ST_WAIT: begin
          if (t.squelch_open) nxt = ST_LISTEN;
          else if (el_s > wait_s) nxt = ST_IDLE;
        end
        ST_TALK: begin
          r.tx_on = 1'b1;
          r.modulation = 1'b1;
          if (!t.squelch_open) nxt = ST_LETTER;
          else if (el_s > talk_s) nxt = ST_ANTI_CHATTER;
        end
        ST_ANTI_CHATTER: begin
          r.tx_on = 1'b1;
          r.cw_key = 1'b1;
          held_msg = MSG_ANTI_CHATTER;
          if (t.cw_done) nxt = ST_BLOCKED;
        end
        ST_BLOCKED: begin
          if (el_s > block_s) nxt = ST_IDLE;
        end
        ST_TEXT_73, ST_TEXT_CALL, ST_TEXT_LONG: begin
          r.tx_on = 1'b1;
          r.modulation = 1'b1;
          r.cw_key = 1'b1;
          if (mode == ST_TEXT_73) held_msg = MSG_73;
          else if (mode == ST_TEXT_CALL) held_msg = MSG_CALL;
          else held_msg = t.random_bits[1] ? MSG_CALL_ALT : MSG_CALL_LOC;
          if (t.squelch_open) nxt = ST_TALK;
          else if (t.cw_done) nxt = ST_IDLE;
        end
        ST_BEACON_LONG, ST_BEACON_SPECIAL, ST_BEACON_SHORT: begin
          r.tx_on = 1'b1;
          r.cw_key = 1'b1;
          if (mode == ST_BEACON_LONG)
            held_msg = t.wind_ok ? MSG_BCN_LONG_73 : MSG_BCN_LONG_SK;
          else if (mode == ST_BEACON_SPECIAL)
            held_msg = t.wind_ok ? MSG_BCN_SPEC_73 : MSG_BCN_SPEC_SK;
          else begin
            case (t.random_bits)
              2'd0:    held_msg = MSG_CALL;
              2'd1:    held_msg = MSG_CALL_LOC;
              2'd2:    held_msg = MSG_CALL_ALT;
              default: held_msg = MSG_CALL_LOC_ALT;
            endcase
          end
          if (t.squelch_open) nxt = ST_OPEN_GONE;
          else if (t.cw_done) nxt = ST_IDLE;
        end
        default: nxt = ST_IDLE;
      endcase
      // entry time is stamped only on a real change of mode
      if (nxt != mode) begin
        entry_ms = t.now_ms;
        if (nxt == ST_OPEN_GONE) open_entry_ms = t.now_ms;
      end
      mode           = nxt;
      r.state_code   = mode;
      r.message_code = held_msg;
      modes_seen[mode]    = 1'b1;
      msgs_seen[held_msg] = 1'b1;
      ticks_noted++;
      expected_updates.push_back(r);
    endfunction

    function void complain(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      else if (mismatches == MAX_REPORTS + 1)
        $display("%0t: further mismatches counted but not shown", $time);
    endfunction

    function void check_update(result_t got);
      result_t want;
      updates_checked++;
      if (expected_updates.size() == 0) begin
        complain("unexpected update beat", 'x, 32'(got));
        return;
      end
      want = expected_updates.pop_front();
      if (got.state_code !== want.state_code)
        complain("state_code", 32'(want.state_code), 32'(got.state_code));
      if (got.tx_on !== want.tx_on)
        complain("tx_on", 32'(want.tx_on), 32'(got.tx_on));
      if (got.modulation !== want.modulation)
        complain("modulation", 32'(want.modulation), 32'(got.modulation));
      if (got.cw_key !== want.cw_key)
        complain("cw_key", 32'(want.cw_key), 32'(got.cw_key));
      if (got.message_code !== want.message_code)
        complain("message_code", 32'(want.message_code), 32'(got.message_code));
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    item_valid;
  logic                    item_ready;
  item_t                   item;
  logic                    result_valid;
  logic                    result_ready;
  result_t                 result;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [15:0]             cfg_data;

  update_scoreboard     sb = new();
  logic [TIME_BITS-1:0] clock_ms;
  bit                   sender_steady;
  bit                   sink_steady;

  // opening ticks: long and special beacons, every letter, listen exits to talk, wait and idle, time extremes
  item_t opening [24] = '{
    {F_NONE,                   2'd0, 48'd0},
    {F_START | F_LOW_POWER,    2'd0, 48'd10},
    {F_WIND | F_DONE,          2'd0, 48'd20},
    {F_START | F_SWR,          2'd0, 48'd30},
    {F_DONE,                   2'd0, 48'd40},
    {F_START,                  2'd0, 48'd50},
    {F_WIND | F_SQUELCH,       2'd0, 48'd60},
    {F_NONE,                   2'd0, 48'd260},
    {F_NONE,                   2'd0, 48'd261},
    {F_LETTERS,                2'd3, 48'd270},
    {F_LETTERS & ~F_SWR,       2'd0, 48'd280},
    {F_FREQ_HIGH | F_LOW_POWER | F_SSTV, 2'd0, 48'd290},
    {F_LOW_POWER | F_SSTV,     2'd0, 48'd300},
    {F_SSTV,                   2'd0, 48'd310},
    {F_DONE,                   2'd0, 48'd320},
    {F_SQUELCH,                2'd0, 48'd400},
    {F_NONE,                   2'd0, 48'd500},
    {F_DONE,                   2'd0, 48'd510},
    {F_NONE,                   2'd0, 48'd7510},
    {F_SQUELCH,                2'd0, 48'd7600},
    {F_NONE,                   2'd0, 48'd13601},
    {F_ALL,                    2'd3, 48'hFFFF_FFFF_FFFF},
    {F_SQUELCH,                2'd0, 48'd0},
    {F_NONE,                   2'd1, 48'd5}
  };

  setting_t plan [6] = '{
    SET_POWER_ON, SET_ALL_ZERO, SET_ALL_MAX, SET_SHORT, SET_RANDOM, SET_DEFAULTS
  };

  repeater_control_fsm_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // timeout
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // random tick, steered by the predicted mode so that deep paths get reached
  function automatic item_t make_tick(bit steer);
    item_t                t;
    int unsigned          pick;
    logic [TIME_BITS-1:0] advance_ms;
    {t.tone_call, t.squelch_open, t.start_beacon, t.cw_done, t.wind_ok} =
      5'($urandom_range(0, 31));
    // condition flags kept sparse so every letter wins now and then
    t.low_power   = chance(30);
    t.swr_alarm   = chance(30);
    t.freq_low    = chance(30);
    t.freq_high   = chance(30);
    t.sstv_on     = chance(30);
    t.random_bits = 2'($urandom_range(0, 3));
    // time advance from sub-second up to hours, now and then a wrap
    pick = $urandom_range(0, 99);
    if (pick < 55) advance_ms = TIME_BITS'($urandom_range(0, 300));
    else if (pick < 75) advance_ms = TIME_BITS'($urandom_range(300, 8000));
    else if (pick < 87) advance_ms = TIME_BITS'($urandom_range(8000, 70000));
    else if (pick < 95) advance_ms = TIME_BITS'($urandom_range(60000, 1500000));
    else if (pick < 98) advance_ms = TIME_BITS'($urandom_range(0, 1 << 27));
    else advance_ms = TIME_BITS'({$urandom, $urandom});
    clock_ms += advance_ms;
    t.now_ms = clock_ms;
    if (steer) begin
      case (sb.mode)
        ST_IDLE: begin
          t.tone_call    = chance(30);
          t.squelch_open = t.tone_call ? chance(90) : chance(20);
          t.start_beacon = chance(10);
        end
        ST_OPEN_TONE:               t.squelch_open = chance(50);
        ST_LETTER, ST_ANTI_CHATTER: t.cw_done = chance(40);
        ST_LISTEN, ST_WAIT:         t.squelch_open = chance(25);
        ST_TALK:                    t.squelch_open = chance(85);
        ST_TEXT_73, ST_TEXT_CALL, ST_TEXT_LONG,
        ST_BEACON_LONG, ST_BEACON_SPECIAL, ST_BEACON_SHORT: begin
          t.squelch_open = chance(15);
          t.cw_done      = chance(40);
        end
        default: ;
      endcase
    end
    return t;
  endfunction

  function automatic logic [15:0] setting_value(setting_t s, logic [15:0] power_on);
    case (s)
      SET_ALL_ZERO: return '0;
      SET_ALL_MAX:  return '1;
      SET_SHORT:    return 16'($urandom_range(0, 20));
      SET_RANDOM:   return 16'($urandom);
      default:      return power_on;
    endcase
  endfunction

  // one tick beat, after a gap of idle cycles
  task automatic send_tick(input item_t t, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= t;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_ready !== 1'b1) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic hold_until_drained(input int extra);
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_settings(input setting_t s);
    write_reg(CFG_BEACON_INTERVAL, setting_value(s, BEACON_INTERVAL_RST));
    write_reg(CFG_OPEN_DELAY,      setting_value(s, OPEN_DELAY_RST));
    write_reg(CFG_WAIT_TIMEOUT,    setting_value(s, WAIT_TIMEOUT_RST));
    write_reg(CFG_TALK_LIMIT,      setting_value(s, TALK_LIMIT_RST));
    write_reg(CFG_BLOCK_TIME,      setting_value(s, BLOCK_TIME_RST));
    // an unmapped index must leave every register alone
    if (s == SET_RANDOM || s == SET_DEFAULTS)
      write_reg(CFG_IDX_BITS'($urandom_range(CFG_UNMAPPED_FIRST, CFG_UNMAPPED_LAST)),
                16'($urandom));
  endtask

  // result beats are checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_ready === 1'b1)
      sb.check_update(result);
  end

  // result side: random stall before each beat, or none in steady stretches
  initial begin : result_sink
    int stall;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = sink_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!(result_valid === 1'b1 && result_ready === 1'b1)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    clock_ms      = '0;
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed ticks at power-on register values
    foreach (opening[i]) send_tick(opening[i], $urandom_range(0, 4));
    clock_ms = opening[23].now_ms;

    // random ticks, one phase per register setting
    for (phase = 0; phase < 6; phase++) begin
      if (plan[phase] != SET_POWER_ON) begin
        hold_until_drained(4);
        program_settings(plan[phase]);
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          sender_steady = chance(25);
          sink_steady   = chance(25);
        end
        if ($urandom_range(0, 149) == 0) hold_until_drained(0);
        send_tick(make_tick(chance(75)), sender_steady ? 0 : $urandom_range(0, 4));
      end
    end

    hold_until_drained(8);
    $display("%0d ticks over %0d register settings, %0d update beats checked",
             sb.ticks_noted, 6, sb.updates_checked);
    $display("modes reached %0d of 15, message codes held %0d of 17",
             $countones(sb.modes_seen), $countones(sb.msgs_seen));
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/rcf_pkg.sv
design/rcf_cfg_regs.sv
design/repeater_control_fsm_core.sv
design/rcf_checker.sv
tb/repeater_control_fsm_core_tb.sv
